// ===== sv/jetp_pkg.sv =====
`timescale 1ns / 1ps

package jetp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_ITER  = 1024;

  localparam int PIX_W  = 11;
  localparam int DIM_W  = 12;
  localparam int FIX_W  = 32;
  localparam int ZOOM_W = 32;
  localparam int LIM_W  = 11;
  localparam int ECNT_W = 10;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  // pixel offset from the frame center and its scaled magnitude
  localparam int OFS_W = PIX_W + 2;
  localparam int MAG_W = 13;

  // divider: magnitude shifted up by 16 + FRAC_BITS over zoom * dimension
  localparam int DIV_SHIFT = 16 + FRAC_BITS;
  localparam int NUM_W     = MAG_W + DIV_SHIFT;
  localparam int DEN_W     = ZOOM_W + DIM_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // multiplier and post-shift widths
  localparam int OPD_W  = FIX_W + 1;
  localparam int PROD_W = 2 * OPD_W;
  localparam int SQ_W   = 2 * FIX_W;
  localparam int SH_W   = SQ_W - FRAC_BITS;
  localparam int SAT_W  = SH_W + 2;
  localparam int QM_W   = FIX_W + 1;
  localparam int QS_W   = FIX_W + 3;

  localparam logic [SQ_W-1:0] ESC_BOUND = SQ_W'(64'd5) << (2 * FRAC_BITS);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZOOM_FACTOR     = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_RE       = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_IM       = 3'd4;
  localparam logic [IDX_W-1:0] REG_CONST_RE        = 3'd5;
  localparam logic [IDX_W-1:0] REG_CONST_IM        = 3'd6;
  localparam logic [IDX_W-1:0] REG_ITERATION_LIMIT = 3'd7;

  localparam logic [DIM_W-1:0]         RST_WIDTH  = 12'd800;
  localparam logic [DIM_W-1:0]         RST_HEIGHT = 12'd600;
  localparam logic [ZOOM_W-1:0]        RST_ZOOM   = 32'd65536;
  localparam logic signed [FIX_W-1:0]  RST_C_RE   = -32'sd11744051;
  localparam logic signed [FIX_W-1:0]  RST_C_IM   = 32'sd4532385;
  localparam logic [LIM_W-1:0]         RST_LIMIT  = 11'd256;

  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-FIX_W:0] hi;
    hi = v[SAT_W-1:FIX_W-1];
    if ((&hi) || !(|hi)) begin
      return v[FIX_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FIX_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== sv/julia_escape_time_pixel.sv =====
`timescale 1ns / 1ps

// done goes high once both axes are mapped and the iterations have run
// (at most the limit); with a zero limit no iteration runs
// mapping: one 53-step bit-serial divide per axis; iteration: one shared multiplier
// throughput: one pixel at a time; a new start is taken in the cycle that done is high
// done is a one-cycle strobe; the receiver cannot stall the result
// rst (synchronous) returns to idle, drops done and loads the register defaults

module julia_escape_time_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [jetp_pkg::PIX_W-1:0]    pixel_x,
  input  logic [jetp_pkg::PIX_W-1:0]    pixel_y,
  output logic                          done,
  output logic [jetp_pkg::PIX_W-1:0]    out_x,
  output logic [jetp_pkg::PIX_W-1:0]    out_y,
  output logic                          escaped,
  output logic [jetp_pkg::ECNT_W-1:0]   escape_count,
  input  logic                          cfg_we,
  input  logic [jetp_pkg::IDX_W-1:0]    cfg_addr,
  input  logic [jetp_pkg::CFG_W-1:0]    cfg_wdata
);
  import jetp_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DEN    = 10'b0000000010,
    ST_DIVGO  = 10'b0000000100,
    ST_DIV    = 10'b0000001000,
    ST_SQ_RE  = 10'b0000010000,
    ST_SQ_IM  = 10'b0000100000,
    ST_CROSS  = 10'b0001000000,
    ST_MAG_RE = 10'b0010000000,
    ST_MAG_IM = 10'b0100000000,
    ST_TEST   = 10'b1000000000
  } state_t;

  state_t state;

  logic [DIM_W-1:0]        width_r;
  logic [DIM_W-1:0]        height_r;
  logic [ZOOM_W-1:0]       zoom_r;
  logic signed [FIX_W-1:0] off_re;
  logic signed [FIX_W-1:0] off_im;
  logic signed [FIX_W-1:0] c_re;
  logic signed [FIX_W-1:0] c_im;
  logic [LIM_W-1:0]        limit_r;

  logic [PIX_W-1:0]        px;
  logic [PIX_W-1:0]        py;
  logic                    axis;
  logic signed [OFS_W-1:0] d;
  logic                    den_zero;
  logic signed [FIX_W-1:0] re;
  logic signed [FIX_W-1:0] im;
  logic signed [SH_W-1:0]  rr;
  logic [SQ_W-1:0]         acc;
  logic [LIM_W-1:0]        iter;
  logic [LIM_W-1:0]        lim;

  logic signed [OPD_W-1:0]  mul_a;
  logic signed [OPD_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [DIM_W-1:0]        dim_sel;
  logic [PIX_W-1:0]        pix_sel;
  logic signed [OFS_W-1:0] d_next;
  logic [OFS_W-1:0]        d_abs;
  logic [PIX_W-1:0]        a;
  logic [MAG_W-1:0]        mag_s;

  logic [NUM_W-1:0]        quo;
  logic                    div_fin;
  logic [QM_W-1:0]         qmag;
  logic signed [QS_W-1:0]  q_s;
  logic signed [FIX_W-1:0] pan;
  logic signed [FIX_W-1:0] map_val;

  logic signed [SH_W-1:0]  prod_sh;
  logic signed [SH_W:0]    prod_sh2;
  logic signed [FIX_W-1:0] nre;
  logic signed [FIX_W-1:0] nim;
  logic [SQ_W-1:0]         mag2;
  logic [LIM_W-1:0]        iter_inc;

  assign busy = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      zoom_r   <= RST_ZOOM;
      off_re   <= '0;
      off_im   <= '0;
      c_re     <= RST_C_RE;
      c_im     <= RST_C_IM;
      limit_r  <= RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:     width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    height_r <= cfg_wdata[DIM_W-1:0];
        REG_ZOOM_FACTOR:     zoom_r   <= cfg_wdata[ZOOM_W-1:0];
        REG_OFFSET_RE:       off_re   <= $signed(cfg_wdata[FIX_W-1:0]);
        REG_OFFSET_IM:       off_im   <= $signed(cfg_wdata[FIX_W-1:0]);
        REG_CONST_RE:        c_re     <= $signed(cfg_wdata[FIX_W-1:0]);
        REG_CONST_IM:        c_im     <= $signed(cfg_wdata[FIX_W-1:0]);
        REG_ITERATION_LIMIT: limit_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel offset and scaled magnitude for the current axis
  always_comb begin
    dim_sel = axis ? height_r : width_r;
    pix_sel = axis ? py : px;
    d_next  = $signed({2'b00, pix_sel}) - $signed({2'b00, dim_sel[DIM_W-1:1]});
    d_abs   = d[OFS_W-1] ? OFS_W'(-d) : OFS_W'(d);
    a       = d_abs[PIX_W-1:0];
    if (axis) begin
      mag_s = {1'b0, a, 1'b0};
    end else begin
      mag_s = {2'b00, a} + {1'b0, a, 1'b0};
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      ST_DEN: begin
        mul_a = $signed({1'b0, zoom_r});
        mul_b = $signed({{(OPD_W-DIM_W){1'b0}}, dim_sel});
      end
      ST_SQ_IM, ST_MAG_IM: begin
        mul_a = OPD_W'(im);
        mul_b = OPD_W'(im);
      end
      ST_CROSS: begin
        mul_a = OPD_W'(re);
        mul_b = OPD_W'(im);
      end
      default: begin
        mul_a = OPD_W'(re);
        mul_b = OPD_W'(re);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  jetp_div u_div (
    .clk (clk),
    .rst (rst),
    .go  (state == ST_DIVGO),
    .mag (mag_s),
    .den (prod[DEN_W-1:0]),
    .quo (quo),
    .fin (div_fin)
  );

  // quotient to mapped coordinate
  always_comb begin
    if (a == '0) begin
      qmag = '0;
    end else if (den_zero) begin
      qmag = QM_W'(33'h0_8000_0000);
    end else if (quo > NUM_W'(64'h1_0000_0000)) begin
      qmag = QM_W'(33'h1_0000_0000);
    end else begin
      qmag = quo[QM_W-1:0];
    end
    q_s     = d[OFS_W-1] ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    pan     = axis ? off_im : off_re;
    map_val = sat32(SAT_W'(q_s) + SAT_W'(pan));
  end

  // z squared plus c
  always_comb begin
    prod_sh  = $signed(prod[SQ_W-1:FRAC_BITS]);
    prod_sh2 = $signed(prod[SQ_W-1:FRAC_BITS-1]);
    nre      = sat32(SAT_W'(rr) - SAT_W'(prod_sh) + SAT_W'(c_re));
    nim      = sat32(SAT_W'(prod_sh2) + SAT_W'(c_im));
    mag2     = acc + prod[SQ_W-1:0];
    iter_inc = iter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            px    <= pixel_x;
            py    <= pixel_y;
            axis  <= 1'b0;
            lim   <= (limit_r > LIM_W'(MAX_ITER)) ? LIM_W'(MAX_ITER) : limit_r;
            state <= ST_DEN;
          end
        end
        ST_DEN: begin
          d     <= d_next;
          state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          den_zero <= (prod[DEN_W-1:0] == '0);
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (div_fin) begin
            if (!axis) begin
              re    <= map_val;
              axis  <= 1'b1;
              state <= ST_DEN;
            end else begin
              im <= map_val;
              if (lim == '0) begin
                done         <= 1'b1;
                out_x        <= px;
                out_y        <= py;
                escaped      <= 1'b0;
                escape_count <= '0;
                state        <= ST_IDLE;
              end else begin
                iter  <= '0;
                state <= ST_SQ_RE;
              end
            end
          end
        end
        ST_SQ_RE: begin
          state <= ST_SQ_IM;
        end
        ST_SQ_IM: begin
          rr    <= prod_sh;
          state <= ST_CROSS;
        end
        ST_CROSS: begin
          re    <= nre;
          state <= ST_MAG_RE;
        end
        ST_MAG_RE: begin
          im    <= nim;
          state <= ST_MAG_IM;
        end
        ST_MAG_IM: begin
          acc   <= prod[SQ_W-1:0];
          state <= ST_TEST;
        end
        ST_TEST: begin
          // re*re for the next iteration is already in the multiplier
          if (mag2 > ESC_BOUND) begin
            done         <= 1'b1;
            out_x        <= px;
            out_y        <= py;
            escaped      <= 1'b1;
            escape_count <= iter[ECNT_W-1:0];
            state        <= ST_IDLE;
          end else if (iter_inc == lim) begin
            done         <= 1'b1;
            out_x        <= px;
            out_y        <= py;
            escaped      <= 1'b0;
            escape_count <= '0;
            state        <= ST_IDLE;
          end else begin
            iter  <= iter_inc;
            state <= ST_SQ_IM;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe outside idle");
  a_no_esc_zero: assert property (@(posedge clk) disable iff (rst)
    done && !escaped |-> escape_count == '0)
    else $error("count set without escape");
  a_iter_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_TEST |-> iter < lim)
    else $error("iteration index past limit");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("start transfer not taken");
  a_div_fin_state: assert property (@(posedge clk) disable iff (rst)
    div_fin |-> state == ST_DIV)
    else $error("divider finished outside mapping");
`endif

endmodule

// ===== sv/jetp_div.sv =====
`timescale 1ns / 1ps

module jetp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [jetp_pkg::MAG_W-1:0]  mag,
  input  logic [jetp_pkg::DEN_W-1:0]  den,
  output logic [jetp_pkg::NUM_W-1:0]  quo,
  output logic                        fin
);
  import jetp_pkg::*;

  logic [NUM_W-1:0]     num_sh;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, num_sh[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    qbit     = !diff[DEN_W];
    rem_next = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      cnt     <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        num_sh  <= {mag, {DIV_SHIFT{1'b0}}};
        rem     <= '0;
        quo     <= '0;
        den_r   <= den;
        cnt     <= DIV_CNT_W'(NUM_W);
        running <= 1'b1;
      end else if (running) begin
        rem    <= rem_next;
        quo    <= {quo[NUM_W-2:0], qbit};
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    running && (den_r != '0) |-> rem < den_r)
    else $error("remainder not below divisor");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin |-> !running)
    else $error("finish while still running");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    running && !go && (cnt == DIV_CNT_W'(1)) |=> fin)
    else $error("missing finish after last step");
  a_go_loads: assert property (@(posedge clk) disable iff (rst)
    go |=> running && (cnt == DIV_CNT_W'(NUM_W)))
    else $error("start did not load the divider");
`endif

endmodule

// ===== tb/sv/julia_escape_time_pixel_tb.sv =====
`timescale 1ns / 1ps

module julia_escape_time_pixel_tb;
  import jetp_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic              esc;
    logic [ECNT_W-1:0] cnt;
  } escape_t;

  localparam longint S32_HI = 2147483647;
  localparam longint S32_LO = -S32_HI - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PIX_W-1:0] pixel_x = '0;
  logic [PIX_W-1:0] pixel_y = '0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic busy;
  logic done;
  logic [PIX_W-1:0] out_x;
  logic [PIX_W-1:0] out_y;
  logic escaped;
  logic [ECNT_W-1:0] escape_count;

  // shadow copy of the register file
  logic [DIM_W-1:0]         m_width  = RST_WIDTH;
  logic [DIM_W-1:0]         m_height = RST_HEIGHT;
  logic [ZOOM_W-1:0]        m_zoom   = RST_ZOOM;
  logic signed [FIX_W-1:0]  m_off_re = '0;
  logic signed [FIX_W-1:0]  m_off_im = '0;
  logic signed [FIX_W-1:0]  m_c_re   = RST_C_RE;
  logic signed [FIX_W-1:0]  m_c_im   = RST_C_IM;
  logic [LIM_W-1:0]         m_limit  = RST_LIMIT;

  pixel_t  pixel_q[$];
  escape_t escape_q[$];

  int     n_issued = 0;
  int     n_checked = 0;
  int     err_cnt = 0;
  int     gap_odds = 2;
  int     gap_left = 0;
  longint cycle_cnt = 0;
  longint cycle_budget = 0;

  julia_escape_time_pixel u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .done         (done),
    .out_x        (out_x),
    .out_y        (out_y),
    .escaped      (escaped),
    .escape_count (escape_count),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_s32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint map_coord(input longint d, input longint unsigned scale,
                                       input longint unsigned den, input longint pan);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? -d : d;
    mag = mag * scale;
    if (mag == 0) begin
      q = 0;
    end else if (den == 0) begin
      q = S32_HI + 1;
    end else begin
      q = longint'((mag << DIV_SHIFT) / den);
    end
    if (d < 0) q = -q;
    return clamp_s32(q + pan);
  endfunction

  function automatic escape_t escape_time(input pixel_t p);
    escape_t r;
    longint re, im, rr, ii, ri, nre, nim;
    longint unsigned mag2, bound, lim;
    int unsigned i;
    re = map_coord(longint'(p.x) - longint'(m_width >> 1), 3,
                   64'(m_zoom) * 64'(m_width), longint'(m_off_re));
    im = map_coord(longint'(p.y) - longint'(m_height >> 1), 2,
                   64'(m_zoom) * 64'(m_height), longint'(m_off_im));
    bound = 64'd5 << (2 * FRAC_BITS);
    lim = (m_limit > MAX_ITER) ? MAX_ITER : m_limit;
    r.x = p.x;
    r.y = p.y;
    r.esc = 1'b0;
    r.cnt = '0;
    for (i = 0; i < lim && !r.esc; i++) begin
      rr = (re * re) >>> FRAC_BITS;
      ii = (im * im) >>> FRAC_BITS;
      ri = (re * im) >>> (FRAC_BITS - 1);
      nre = clamp_s32(rr - ii + longint'(m_c_re));
      nim = clamp_s32(ri + longint'(m_c_im));
      mag2 = $unsigned(nre * nre) + $unsigned(nim * nim);
      re = nre;
      im = nim;
      if (mag2 > bound) begin
        r.esc = 1'b1;
        r.cnt = ECNT_W'(i);
      end
    end
    return r;
  endfunction

  function automatic void queue_pixel(input int unsigned x, input int unsigned y);
    pixel_t p;
    longint lim;
    p.x = x[PIX_W-1:0];
    p.y = y[PIX_W-1:0];
    pixel_q.push_back(p);
    n_issued++;
    lim = (m_limit > MAX_ITER) ? MAX_ITER : m_limit;
    cycle_budget += 180 + 5 * lim + 20;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("%s got %0d expected %0d (pixel %0d,%0d)",
                              name, got, want, escape_q[0].x, escape_q[0].y));
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_IMAGE_WIDTH:     m_width  = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT:    m_height = val[DIM_W-1:0];
      REG_ZOOM_FACTOR:     m_zoom   = val[ZOOM_W-1:0];
      REG_OFFSET_RE:       m_off_re = val[FIX_W-1:0];
      REG_OFFSET_IM:       m_off_im = val[FIX_W-1:0];
      REG_CONST_RE:        m_c_re   = val[FIX_W-1:0];
      REG_CONST_IM:        m_c_im   = val[FIX_W-1:0];
      REG_ITERATION_LIMIT: m_limit  = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] zoom, input logic [CFG_W-1:0] ore,
                             input logic [CFG_W-1:0] oim, input logic [CFG_W-1:0] cre,
                             input logic [CFG_W-1:0] cim, input logic [CFG_W-1:0] lim);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ZOOM_FACTOR, zoom);
    write_reg(REG_OFFSET_RE, ore);
    write_reg(REG_OFFSET_IM, oim);
    write_reg(REG_CONST_RE, cre);
    write_reg(REG_CONST_IM, cim);
    write_reg(REG_ITERATION_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (n_checked != n_issued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold until transfer
    end else if (gap_left != 0) begin
      if (!busy) gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      if (start) begin
        escape_q.push_back(escape_time({pixel_x, pixel_y}));
      end
      if (start && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        gap_left <= $urandom_range(1, 19);
        start    <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pixel_x <= pixel_q[0].x;
        pixel_y <= pixel_q[0].y;
        start   <= 1'b1;
        pixel_q.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (escape_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending (pixel %0d,%0d)",
                                out_x, out_y));
      end else begin
        check_field("out_x", out_x, escape_q[0].x);
        check_field("out_y", out_y, escape_q[0].y);
        check_field("escaped", escaped, escape_q[0].esc);
        check_field("escape_count", escape_count, escape_q[0].cnt);
        escape_q.delete(0);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 4 * cycle_budget + 50000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    logic [CFG_W-1:0] w, h, zm, ore, oim, cre, cim, lim;
    int unsigned span_x, span_y;
    int ph, k, nitems;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // register defaults after reset
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    queue_pixel(400, 300);
    queue_pixel(799, 599);
    queue_pixel(0, 2047);
    drain();

    // zero zoom, divisor is zero
    load_config(800, 600, 0, 0, 0, RST_C_RE, RST_C_IM, 16);
    queue_pixel(400, 300);
    queue_pixel(401, 299);
    queue_pixel(399, 301);
    drain();
    load_config(800, 600, 0, 32'h80000000, 32'h7FFFFFFF, RST_C_RE, RST_C_IM, 16);
    queue_pixel(401, 301);
    queue_pixel(399, 299);
    drain();

    // zero dimensions
    load_config(0, 0, 32'h10000, 0, 0, RST_C_RE, RST_C_IM, 16);
    queue_pixel(0, 0);
    queue_pixel(5, 7);
    drain();

    // zero iteration limit
    load_config(800, 600, 32'h10000, 0, 0, RST_C_RE, RST_C_IM, 0);
    queue_pixel(400, 300);
    queue_pixel(0, 0);
    drain();

    // pixels beyond a small frame
    load_config(16, 16, 32'h10000, 0, 0, RST_C_RE, RST_C_IM, 32);
    queue_pixel(2047, 2047);
    queue_pixel(16, 8);
    queue_pixel(8, 16);
    drain();

    // extreme zoom, pans and constants
    load_config(2048, 2048, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 8);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    drain();
    load_config(4095, 4095, 1, 0, 0, 0, 0, 4);
    queue_pixel(2047, 0);
    queue_pixel(0, 2047);
    drain();

    // limit above the maximum is clamped, z stays at zero for the center pixel
    load_config(800, 600, 32'h10000, 0, 0, 0, 0, 2047);
    queue_pixel(400, 300);
    queue_pixel(401, 300);
    drain();

    for (ph = 0; ph < 14; ph++) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(16, 2048);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(16, 2048);
      w[CFG_W-1:DIM_W] = $urandom;
      h[CFG_W-1:DIM_W] = $urandom;
      case ($urandom_range(0, 7))
        0: zm = $urandom;
        1: zm = $urandom_range(0, 2) == 0 ? 32'd0 :
                ($urandom_range(0, 1) ? 32'd1 : 32'hFFFFFFFF);
        default: zm = $urandom_range(32'h8000, 32'h80000);
      endcase
      ore = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h4000000) - 32'h2000000;
      oim = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h4000000) - 32'h2000000;
      cre = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h2000000) - 32'h1000000;
      cim = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h2000000) - 32'h1000000;
      if (ph == 11) begin
        lim = $urandom_range(512, 2047);
        nitems = 6;
      end else begin
        lim = $urandom_range(0, 7) == 0 ? $urandom_range(0, 200) : $urandom_range(1, 40);
        nitems = 55;
      end
      lim[CFG_W-1:LIM_W] = $urandom;
      gap_odds = (ph >= 12) ? 0 : $urandom_range(0, 3);
      load_config(w, h, zm, ore, oim, cre, cim, lim);
      span_x = (m_width == 0 || m_width > 2048) ? 2048 : m_width;
      span_y = (m_height == 0 || m_height > 2048) ? 2048 : m_height;
      for (k = 0; k < nitems; k++) begin
        queue_pixel($urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
                                               : $urandom_range(0, span_x - 1),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
                                               : $urandom_range(0, span_y - 1));
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (escape_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", escape_q.size()));
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
